// File: design/assert_macros.svh
// Assertion macros used by the checker of this block.
// Each macro asserts one clocked property and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SOPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sopc assertion failed");

// Next-cycle implication.
`define SOPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sopc assertion failed");

`endif

// File: design/sopc_pkg.sv
// Package for the stack pop order checker: verdict codes, request codes,
// default sizes and the verdict hand-off struct. No dependencies.
`default_nettype none

package sopc_pkg;

  localparam int unsigned DEF_MAX_LEN     = 1024;
  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned IN_VALUE_W      = 32;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_OK    = 2'd0;
  localparam verdict_t VERDICT_LEN   = 2'd1;
  localparam verdict_t VERDICT_ORDER = 2'd2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic     load;
    verdict_t verdict;
  } verdict_req_t;

endpackage

`default_nettype wire

// File: design/sopc_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module sopc_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/sopc_outreg.sv
// Output register for the verdict channel; frees the sequencer from the
// consumer's stall. Depends on sopc_pkg.
`default_nettype none

module sopc_outreg
  import sopc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  verdict_req_t req,
  output logic         free,
  output logic         out_valid,
  input  logic         out_stall,
  output verdict_t     verdict
);

  // The slot can take a new word when empty or when the held word leaves now.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      verdict <= req.verdict;
    end
  end

endmodule

`default_nettype wire

// File: design/sopc_seq.sv
// Sequencer of the stack pop order checker: counters, stack top cache and the
// read-modify-write control of the push and stack memories. Depends on sopc_pkg.
`default_nettype none

module sopc_seq
  import sopc_pkg::*;
#(
  parameter int unsigned MAX_LEN     = DEF_MAX_LEN,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned ADDR_W = $clog2(MAX_LEN)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic signed [IN_VALUE_W-1:0] value,
  input  logic                    last,
  output verdict_req_t            out_req,
  input  logic                    out_free,
  output logic                    push_wr_en,
  output logic [ADDR_W-1:0]       push_wr_addr,
  output logic [VALUE_WIDTH-1:0]  push_wr_data,
  output logic                    push_rd_en,
  output logic [ADDR_W-1:0]       push_rd_addr,
  input  logic [VALUE_WIDTH-1:0]  push_rd_data,
  output logic                    stack_wr_en,
  output logic [ADDR_W-1:0]       stack_wr_addr,
  output logic [VALUE_WIDTH-1:0]  stack_wr_data,
  output logic                    stack_rd_en,
  output logic [ADDR_W-1:0]       stack_rd_addr,
  input  logic [VALUE_WIDTH-1:0]  stack_rd_data
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 2);
  localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] POP_SAT   = CNT_W'(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_CHECK   = 2'd1;
  localparam logic [1:0] ST_PUSH    = 2'd2;
  localparam logic [1:0] ST_VERDICT = 2'd3;

  logic [1:0]             state, state_next;
  logic [CNT_W-1:0]       push_count, push_count_next;
  logic [CNT_W-1:0]       push_ptr, push_ptr_next;
  logic [CNT_W-1:0]       depth, depth_next;
  logic [CNT_W-1:0]       pop_count, pop_count_next;
  logic                   order_failed, order_failed_next;
  logic                   in_pop, in_pop_next;
  logic [VALUE_WIDTH-1:0] top, top_next;
  logic                   top_ok, top_ok_next;
  logic [VALUE_WIDTH-1:0] cur_val, cur_val_next;
  logic                   cur_last, cur_last_next;

  logic [VALUE_WIDTH-1:0] val_ext;
  logic [VALUE_WIDTH-1:0] top_val;
  logic [CNT_W-1:0]       ptr_inc;
  logic [CNT_W-1:0]       depth_dec;
  logic                   has_top;
  logic [1:0]             finish_state;

  // Sign extension or truncation of the incoming word to the compare width.
  assign val_ext   = VALUE_WIDTH'(value);
  assign ptr_inc   = push_ptr + ONE;
  assign depth_dec = depth - ONE;
  assign has_top   = (depth != '0);
  // The top of stack comes from the cache, or from the read issued at accept.
  assign top_val   = top_ok ? top : stack_rd_data;
  assign finish_state = cur_last ? ST_VERDICT : ST_IDLE;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next        = state;
    push_count_next   = push_count;
    push_ptr_next     = push_ptr;
    depth_next        = depth;
    pop_count_next    = pop_count;
    order_failed_next = order_failed;
    in_pop_next       = in_pop;
    top_next          = top;
    top_ok_next       = top_ok;
    cur_val_next      = cur_val;
    cur_last_next     = cur_last;

    push_wr_en    = 1'b0;
    push_wr_addr  = push_count[ADDR_W-1:0];
    push_wr_data  = val_ext;
    push_rd_en    = 1'b0;
    push_rd_addr  = push_ptr[ADDR_W-1:0];
    stack_wr_en   = 1'b0;
    stack_wr_addr = depth[ADDR_W-1:0];
    stack_wr_data = push_rd_data;
    stack_rd_en   = 1'b0;
    stack_rd_addr = depth_dec[ADDR_W-1:0];
    out_req       = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_PUSH) begin
            if (!in_pop && (push_count < LEN_LIMIT)) begin
              push_wr_en      = 1'b1;
              push_count_next = push_count + ONE;
            end
          end else begin
            in_pop_next   = 1'b1;
            cur_val_next  = val_ext;
            cur_last_next = last;
            if (pop_count != POP_SAT) begin
              pop_count_next = pop_count + ONE;
            end
            if (order_failed) begin
              state_next = last ? ST_VERDICT : ST_IDLE;
            end else begin
              stack_rd_en = has_top && !top_ok;
              state_next  = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (has_top && (top_val == cur_val)) begin
          depth_next  = depth_dec;
          top_ok_next = 1'b0;
          state_next  = finish_state;
        end else begin
          top_next    = top_val;
          top_ok_next = has_top;
          if (push_ptr < push_count) begin
            push_rd_en = 1'b1;
            state_next = ST_PUSH;
          end else begin
            order_failed_next = 1'b1;
            state_next        = finish_state;
          end
        end
      end
      ST_PUSH: begin
        push_ptr_next = ptr_inc;
        if (push_rd_data == cur_val) begin
          // Pushed and popped at once: the stack below is untouched.
          state_next = finish_state;
        end else begin
          stack_wr_en = 1'b1;
          top_next    = push_rd_data;
          top_ok_next = 1'b1;
          depth_next  = depth + ONE;
          if (ptr_inc < push_count) begin
            push_rd_en   = 1'b1;
            push_rd_addr = ptr_inc[ADDR_W-1:0];
          end else begin
            order_failed_next = 1'b1;
            state_next        = finish_state;
          end
        end
      end
      ST_VERDICT: begin
        if (out_free) begin
          out_req.load = 1'b1;
          if (pop_count != push_count) begin
            out_req.verdict = VERDICT_LEN;
          end else if (order_failed) begin
            out_req.verdict = VERDICT_ORDER;
          end else begin
            out_req.verdict = VERDICT_OK;
          end
          push_count_next   = '0;
          push_ptr_next     = '0;
          depth_next        = '0;
          pop_count_next    = '0;
          order_failed_next = 1'b0;
          in_pop_next       = 1'b0;
          top_ok_next       = 1'b0;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      push_count   <= '0;
      push_ptr     <= '0;
      depth        <= '0;
      pop_count    <= '0;
      order_failed <= 1'b0;
      in_pop       <= 1'b0;
      top_ok       <= 1'b0;
    end else begin
      state        <= state_next;
      push_count   <= push_count_next;
      push_ptr     <= push_ptr_next;
      depth        <= depth_next;
      pop_count    <= pop_count_next;
      order_failed <= order_failed_next;
      in_pop       <= in_pop_next;
      top_ok       <= top_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    cur_val  <= cur_val_next;
    cur_last <= cur_last_next;
  end

endmodule

`default_nettype wire

// File: design/stack_pop_order_checker_top.sv
// Top level of the stack pop order checker: sequencer, push and stack memories
// and the verdict output register. Depends on sopc_pkg and the sopc_* modules.
//
//   channel   handshake             payload
//   input     in_valid / in_stall   req_type, value, last
//   output    out_valid / out_stall verdict
//
// A push word is taken in the idle state. A pop word goes to the check step and then
// to the push step for each stored value it reads, or stays in the idle state once
// the order has failed; the last word then passes the verdict step, which hands the
// verdict to the output register. Both memories have registered read data.
// Reset clears all counters and flags; the memories are not cleared. A stalled
// verdict holds the sequencer in its final step only while the output register is full.
`default_nettype none

module stack_pop_order_checker_top
  import sopc_pkg::*;
#(
  parameter int unsigned MAX_LEN     = DEF_MAX_LEN,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic signed [IN_VALUE_W-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output verdict_t                     verdict
);

  localparam int unsigned ADDR_W = $clog2(MAX_LEN);

  verdict_req_t           out_req;
  logic                   out_free;
  logic                   push_wr_en, push_rd_en, stack_wr_en, stack_rd_en;
  logic [ADDR_W-1:0]      push_wr_addr, push_rd_addr, stack_wr_addr, stack_rd_addr;
  logic [VALUE_WIDTH-1:0] push_wr_data, push_rd_data, stack_wr_data, stack_rd_data;

  sopc_seq #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .value         (value),
    .last          (last),
    .out_req       (out_req),
    .out_free      (out_free),
    .push_wr_en    (push_wr_en),
    .push_wr_addr  (push_wr_addr),
    .push_wr_data  (push_wr_data),
    .push_rd_en    (push_rd_en),
    .push_rd_addr  (push_rd_addr),
    .push_rd_data  (push_rd_data),
    .stack_wr_en   (stack_wr_en),
    .stack_wr_addr (stack_wr_addr),
    .stack_wr_data (stack_wr_data),
    .stack_rd_en   (stack_rd_en),
    .stack_rd_addr (stack_rd_addr),
    .stack_rd_data (stack_rd_data)
  );

  sopc_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_WIDTH)
  ) u_push_ram (
    .clk     (clk),
    .wr_en   (push_wr_en),
    .wr_addr (push_wr_addr),
    .wr_data (push_wr_data),
    .rd_en   (push_rd_en),
    .rd_addr (push_rd_addr),
    .rd_data (push_rd_data)
  );

  sopc_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_WIDTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_wr_en),
    .wr_addr (stack_wr_addr),
    .wr_data (stack_wr_data),
    .rd_en   (stack_rd_en),
    .rd_addr (stack_rd_addr),
    .rd_data (stack_rd_data)
  );

  sopc_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .req       (out_req),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
  );

endmodule

`default_nettype wire

// File: design/sopc_checker.sv
// Port-level checker for the stack pop order checker, bound to the top level.
// Depends on sopc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sopc_checker
  import sopc_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         req_type,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_stall,
  input verdict_t                     verdict
);

  logic push_acc;
  logic last_pop_acc;

  assign push_acc     = in_valid && !in_stall && (req_type == REQ_PUSH);
  assign last_pop_acc = in_valid && !in_stall && (req_type == REQ_POP) && last;

  // A held verdict word does not change or vanish while stalled.
  `SOPC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(verdict))
  // A push word never keeps the block busy.
  `SOPC_ASSERT_NXT(a_push_one_cycle, clk, rst, push_acc, !in_stall)
  // The final pop word always keeps the block busy after it is accepted.
  `SOPC_ASSERT_NXT(a_last_pop_busy, clk, rst, last_pop_acc, in_stall)
  // A verdict only appears right after the block was busy with a pop word.
  `SOPC_ASSERT_IMP(a_verdict_source, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind stack_pop_order_checker_top sopc_checker u_sopc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_pop_order_checker_top: predicts each verdict
// from the accepted words and compares it with the block's output. Needs sopc_pkg.
module tb_top
  import sopc_pkg::*;
;

  localparam int unsigned MAX_LEN    = DEF_MAX_LEN;
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned HOLD_LEN   = 120;
  localparam int unsigned CALM_FROM  = 600;
  localparam int unsigned CALM_TO    = 1000;
  localparam int unsigned ITEMS      = 1350;
  localparam int unsigned LONG_POPS  = 4;
  localparam int unsigned LONG_WORDS = MAX_LEN + 3 + LONG_POPS;

  typedef enum {
    SEQ_VALID, SEQ_REVERSE, SEQ_SWAP, SEQ_SHUFFLE, SEQ_CORRUPT,
    SEQ_SHORT, SEQ_LATE_PUSH, SEQ_NOISE
  } seq_kind_t;

  typedef struct packed {
    logic        drain;
    logic        kind;
    logic [31:0] val;
    logic        lst;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_PUSH;
  logic signed [IN_VALUE_W-1:0] value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  verdict_t verdict;

  word_t pending[$];
  word_t cur_word;
  bit drain_next = 1'b0;
  verdict_t verdicts_due[$];
  int unsigned n_predicted = 0;
  int unsigned n_checked = 0;
  int unsigned n_mismatch = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  bit calm;

  // Shadow copy of the sequencer state.
  logic [31:0] pushed_vals [MAX_LEN];
  logic [31:0] stack_vals [MAX_LEN];
  int unsigned n_pushed, next_push, depth, n_popped;
  bit order_bad, popping;

  stack_pop_order_checker_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .value    (value),
    .last     (last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict  (verdict)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  function automatic void clear_shadow();
    n_pushed  = 0;
    next_push = 0;
    depth     = 0;
    n_popped  = 0;
    order_bad = 1'b0;
    popping   = 1'b0;
  endfunction

  // Applies one accepted word; returns 1 when it yields a verdict.
  function automatic bit predict_word(word_t w);
    verdict_t vd;
    if (w.kind == REQ_PUSH) begin
      if (!popping && n_pushed < MAX_LEN) begin
        pushed_vals[n_pushed] = w.val;
        n_pushed++;
      end
      return 1'b0;
    end
    popping = 1'b1;
    if (n_popped < MAX_LEN + 1) n_popped++;
    if (!order_bad) begin
      while ((depth == 0 || stack_vals[depth-1] != w.val) && next_push < n_pushed &&
             depth < MAX_LEN) begin
        stack_vals[depth] = pushed_vals[next_push];
        depth++;
        next_push++;
      end
      if (depth != 0 && stack_vals[depth-1] == w.val) depth--;
      else order_bad = 1'b1;
    end
    if (!w.lst) return 1'b0;
    if (n_popped != n_pushed) vd = VERDICT_LEN;
    else if (order_bad) vd = VERDICT_ORDER;
    else vd = VERDICT_OK;
    verdicts_due.push_back(vd);
    clear_shadow();
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(2) != 0) return $urandom;
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hffff_ffff;
      3: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic queue_word(logic kind, logic [31:0] v, logic lst);
    word_t w;
    w.drain = drain_next;
    w.kind  = kind;
    w.val   = v;
    w.lst   = lst;
    pending.push_back(w);
    drain_next = 1'b0;
  endtask

  // Builds a push sequence and a pop sequence, legal or broken as asked, or for noise a random mix of words.
  task automatic queue_sequence(int unsigned n, seq_kind_t kind, int unsigned extra_push,
                                int unsigned more_pops);
    logic [31:0] vals[$];
    logic [31:0] order[$];
    logic [31:0] held[$];
    logic [31:0] t;
    int unsigned i, a, b, nxt;
    for (i = 0; i < n; i++) vals.push_back(pick_value());
    if (kind == SEQ_NOISE) begin
      for (i = 0; i < n; i++)
        queue_word(1'($urandom_range(1)), pick_value(), 1'($urandom_range(1)));
      queue_word(REQ_POP, pick_value(), 1'b1);
      return;
    end
    for (i = 0; i < n; i++) queue_word(REQ_PUSH, vals[i], $urandom_range(3) == 0);
    for (i = 0; i < extra_push; i++) queue_word(REQ_PUSH, pick_value(), 1'b0);
    if (kind == SEQ_REVERSE) begin
      for (i = n; i > 0; i--) order.push_back(vals[i-1]);
    end else begin
      nxt = 0;
      while (order.size() < n) begin
        if (nxt < n && (held.size() == 0 || $urandom_range(1) == 1)) begin
          held.push_back(vals[nxt]);
          nxt++;
        end else begin
          order.push_back(held.pop_back());
        end
      end
    end
    case (kind)
      SEQ_SWAP: begin
        if (order.size() >= 2) begin
          a = $urandom_range(order.size() - 1);
          b = $urandom_range(order.size() - 1);
          t = order[a];
          order[a] = order[b];
          order[b] = t;
        end
      end
      SEQ_SHUFFLE: begin
        for (i = order.size(); i > 1; i--) begin
          a = $urandom_range(i - 1);
          t = order[a];
          order[a] = order[i-1];
          order[i-1] = t;
        end
      end
      SEQ_CORRUPT: begin
        if (order.size() > 0) order[$urandom_range(order.size() - 1)] = pick_value();
      end
      SEQ_SHORT: begin
        if (order.size() > 1) void'(order.pop_back());
      end
      default: ;
    endcase
    for (i = 0; i < more_pops; i++) order.push_back(pick_value());
    if (order.size() == 0) order.push_back(pick_value());
    for (i = 0; i < order.size(); i++) begin
      // Pushes inside the pop phase must be ignored by the block.
      if (kind == SEQ_LATE_PUSH && $urandom_range(2) == 0)
        queue_word(REQ_PUSH, pick_value(), 1'($urandom_range(1)));
      queue_word(REQ_POP, order[i], i == order.size() - 1);
    end
  endtask

  // Driver: presents the next word when the current one has been taken, save for random gaps and drain waits.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_word(cur_word)) n_predicted <= n_predicted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() == 0 || (!calm && $urandom_range(99) < 23)) begin
          in_valid <= 1'b0;
        end else if (pending[0].drain && (in_valid || n_predicted != n_checked)) begin
          in_valid <= 1'b0;
        end else begin
          cur_word = pending.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_word.kind;
          value    <= cur_word.val;
          last     <= cur_word.lst;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (cyc == HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  // Monitor: each verdict word is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %0d", $time, verdict);
        n_mismatch++;
      end else begin
        if (verdict !== verdicts_due[0]) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, verdicts_due[0], verdict);
          n_mismatch++;
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  initial begin
    int unsigned n_seq, n, r, i;
    seq_kind_t k;
    clear_shadow();

    // Extreme values, a legal order.
    queue_word(REQ_PUSH, 32'h7fff_ffff, 1'b0);
    queue_word(REQ_PUSH, 32'h8000_0000, 1'b0);
    queue_word(REQ_POP, 32'h8000_0000, 1'b0);
    queue_word(REQ_POP, 32'h7fff_ffff, 1'b1);
    // Last flag on a push word is ignored.
    queue_word(REQ_PUSH, 32'h0000_0000, 1'b0);
    queue_word(REQ_PUSH, 32'hffff_ffff, 1'b1);
    queue_word(REQ_POP, 32'h0000_0000, 1'b0);
    queue_word(REQ_POP, 32'hffff_ffff, 1'b1);
    // Order violation, then a pop after the failure.
    queue_word(REQ_PUSH, 32'd1, 1'b0);
    queue_word(REQ_PUSH, 32'd2, 1'b0);
    queue_word(REQ_PUSH, 32'd3, 1'b0);
    queue_word(REQ_POP, 32'd3, 1'b0);
    queue_word(REQ_POP, 32'd1, 1'b0);
    queue_word(REQ_POP, 32'd2, 1'b1);
    // Pop with nothing stored left, giving a length mismatch.
    queue_word(REQ_PUSH, 32'd5, 1'b0);
    queue_word(REQ_POP, 32'd5, 1'b0);
    queue_word(REQ_POP, 32'd5, 1'b1);
    // Pop-only sequence.
    queue_word(REQ_POP, 32'd9, 1'b1);
    // Push after pops began is dropped.
    queue_word(REQ_PUSH, 32'd7, 1'b0);
    queue_word(REQ_PUSH, 32'd8, 1'b0);
    queue_word(REQ_POP, 32'd8, 1'b0);
    queue_word(REQ_PUSH, 32'd4, 1'b0);
    queue_word(REQ_POP, 32'd7, 1'b1);

    n_seq = 0;
    while (pending.size() < ITEMS - LONG_WORDS) begin
      if (n_seq == 5) drain_next = 1'b1;
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      r = $urandom_range(99);
      if (r < 45) k = SEQ_VALID;
      else if (r < 52) k = SEQ_REVERSE;
      else if (r < 62) k = SEQ_SWAP;
      else if (r < 70) k = SEQ_SHUFFLE;
      else if (r < 78) k = SEQ_CORRUPT;
      else if (r < 84) k = SEQ_SHORT;
      else if (r < 91) k = SEQ_LATE_PUSH;
      else if (r < 96) k = SEQ_NOISE;
      else k = SEQ_VALID;
      if (r >= 96) queue_sequence(0, k, 0, $urandom_range(3, 1));
      else queue_sequence(n, k, 0,
                          ($urandom_range(19) == 0) ? $urandom_range(3, 1) : 0);
      n_seq++;
    end

    // Overlong push sequence; the first pop moves all but one stored value
    // onto the stack, so the stack gets nearly full.
    for (i = 0; i < MAX_LEN + 3; i++) queue_word(REQ_PUSH, 32'(i), 1'b0);
    for (i = 0; i < LONG_POPS; i++)
      queue_word(REQ_POP, 32'(MAX_LEN - 1 - i), i == LONG_POPS - 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (n_checked != n_predicted) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_mismatch == 0 && verdicts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
